>>> src/dnbt_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dnbt_pkg
// Shared types, constants and the log2 table builder for the thermal-band
// brightness temperature pipeline.
// -----------------------------------------------------------------------------
package dnbt_pkg;

	// pixel width actually used and table resolution
	localparam int PIXEL_BITS     = 16;
	localparam int LOG_TABLE_BITS = 10;
	localparam int DN_BITS        = (PIXEL_BITS < 16) ? PIXEL_BITS : 16;

	// log table geometry
	localparam int ROM_DEPTH = (1 << LOG_TABLE_BITS) + 1;
	localparam int ROM_AW    = LOG_TABLE_BITS + 1;
	localparam int ROM_W     = 25;
	localparam int REM_BITS  = 32 - LOG_TABLE_BITS;

	// natural log conversion factor, ln(2) in Q.32
	localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

	// log2 result (Q.24, up to 17.0) and ln result widths
	localparam int L2_W = 29;
	localparam int LN_W = 29;

	// divider remainder width and quotient bits
	localparam int DIV_W = 33;
	localparam int Q_W   = 32;

	// register indexes
	localparam logic [2:0] REG_GAIN    = 3'd0;
	localparam logic [2:0] REG_OFFSET  = 3'd1;
	localparam logic [2:0] REG_K1      = 3'd2;
	localparam logic [2:0] REG_K2      = 3'd3;
	localparam logic [2:0] REG_NODATA  = 3'd4;
	localparam logic [2:0] REG_ND_EN   = 3'd5;

	typedef enum logic [1:0] {
		ST_VALID  = 2'd0,
		ST_NODATA = 2'd1,
		ST_BADRAD = 2'd2
	} status_t;

	// control that travels with each word
	typedef struct packed {
		logic    valid;
		status_t status;
	} ctl_t;

	typedef logic [ROM_W-1:0] rom_t [0:ROM_DEPTH-1];

	// log2 of a Q2.30 mantissa in [1,2], Q.24, truncating repeated squaring
	function automatic logic [ROM_W-1:0] log2_mant(logic [63:0] m_in);
		logic [63:0] m;
		logic [ROM_W-1:0] r;
		m = m_in;
		r = '0;
		if (m >= 64'h8000_0000) begin
			r = ROM_W'(1) << 24;
		end else begin
			for (int k = 0; k < 24; k++) begin
				r = r << 1;
				m = (m * m) >> 30;
				if (m >= 64'h8000_0000) begin
					m = m >> 1;
					r[0] = 1'b1;
				end
			end
		end
		return r;
	endfunction

	function automatic rom_t build_rom();
		rom_t t;
		for (int i = 0; i < ROM_DEPTH; i++) begin
			t[i] = log2_mant((64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS)));
		end
		return t;
	endfunction

endpackage

>>> src/dnbt_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dnbt_in_if / dnbt_out_if
// Valid/ready channels for pixel words and result words.
// -----------------------------------------------------------------------------
interface dnbt_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel_dn;
	modport source(output valid, output pixel_dn, input ready);
	modport sink(input valid, input pixel_dn, output ready);
endinterface

interface dnbt_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] temperature_q16_16;
	logic [1:0]  pixel_status;
	modport source(output valid, output temperature_q16_16, output pixel_status, input ready);
	modport sink(input valid, input temperature_q16_16, input pixel_status, output ready);
endinterface

>>> src/dnbt_front.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dnbt_front
// Rescales a pixel to Q16.16 radiance and classifies no-data / bad radiance.
// -----------------------------------------------------------------------------
module dnbt_front import dnbt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [15:0] pixel_dn,
	input  logic [31:0] gain,
	input  logic [31:0] offset,
	input  logic [15:0] nodata_pixel,
	input  logic        nodata_enable,
	output ctl_t        ctl_s2,
	output logic [30:0] rad_s2
);

	logic [15:0]        dn;
	logic signed [48:0] p_s1;
	ctl_t               ctl_s1;
	logic signed [48:0] rnd;
	logic signed [49:0] sum;
	status_t            st_next;
	logic [30:0]        rad_next;

	assign dn = 16'(pixel_dn[DN_BITS-1:0]);

	// stage 1: product and no-data match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '{valid: 1'b0, status: ST_VALID};
		end else if (en) begin
			ctl_s1.valid  <= in_valid;
			ctl_s1.status <= (nodata_enable && dn == nodata_pixel) ? ST_NODATA : ST_VALID;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= $signed(gain) * $signed({1'b0, dn});
		end
	end

	// stage 2: round to Q16.16, add offset, saturate
	always_comb begin
		rnd = (p_s1 + 49'sd128) >>> 8;
		sum = {rnd[48], rnd} + {{18{offset[31]}}, offset};
		st_next = ctl_s1.status;
		if (ctl_s1.status == ST_VALID && sum <= 50'sd0) begin
			st_next = ST_BADRAD;
		end
		if (sum > 50'sd2147483647) begin
			rad_next = '1;
		end else begin
			rad_next = sum[30:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '{valid: 1'b0, status: ST_VALID};
		end else if (en) begin
			ctl_s2.valid  <= ctl_s1.valid;
			ctl_s2.status <= st_next;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s2 <= rad_next;
		end
	end

endmodule

>>> src/dnbt_div.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dnbt_div
// Pipelined restoring divider, one quotient bit per stage, saturating.
// The caller hands in the partial remainder after the high dividend bits.
// -----------------------------------------------------------------------------
module dnbt_div import dnbt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  ctl_t             ctl_in,
	input  logic [DIV_W-1:0] rem0,
	input  logic [Q_W-1:0]   num,
	input  logic [DIV_W-1:0] den,
	input  logic             sat,
	output ctl_t             ctl_out,
	output logic [Q_W-1:0]   quot
);

	ctl_t             ctl_q [0:Q_W];
	logic [DIV_W-1:0] r_q   [0:Q_W];
	logic [Q_W-1:0]   n_q   [0:Q_W];
	logic [DIV_W-1:0] d_q   [0:Q_W];
	logic [Q_W-1:0]   q_q   [0:Q_W];
	logic             sat_q [0:Q_W];

	// entry stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q[0] <= '{valid: 1'b0, status: ST_VALID};
		end else if (en) begin
			ctl_q[0] <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_q[0]   <= rem0;
			n_q[0]   <= num;
			d_q[0]   <= den;
			q_q[0]   <= '0;
			sat_q[0] <= sat;
		end
	end

	// one trial subtract per stage
	for (genvar k = 1; k <= Q_W; k++) begin : g_step
		logic [DIV_W-1:0] rem_sh;
		logic [DIV_W:0]   diff;
		logic             ge;

		assign rem_sh = {r_q[k-1][DIV_W-2:0], n_q[k-1][Q_W-1]};
		assign diff   = {1'b0, rem_sh} - {1'b0, d_q[k-1]};
		assign ge     = !diff[DIV_W];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_q[k] <= '{valid: 1'b0, status: ST_VALID};
			end else if (en) begin
				ctl_q[k] <= ctl_q[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_q[k]   <= ge ? diff[DIV_W-1:0] : rem_sh;
				n_q[k]   <= n_q[k-1] << 1;
				d_q[k]   <= d_q[k-1];
				q_q[k]   <= {q_q[k-1][Q_W-2:0], ge};
				sat_q[k] <= sat_q[k-1];
			end
		end
	end

	assign ctl_out = ctl_q[Q_W];
	assign quot    = sat_q[Q_W] ? '1 : q_q[Q_W];

endmodule

>>> src/dnbt_log.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dnbt_log
// Natural log of (x + 1.0) in Q.24: normalize, table lookup with linear
// interpolation, then scale by ln(2).
// -----------------------------------------------------------------------------
module dnbt_log import dnbt_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  ctl_t            ctl_in,
	input  logic [31:0]     x,
	output ctl_t            ctl_out,
	output logic [LN_W-1:0] ln
);

	localparam rom_t LOG_ROM = build_rom();

	ctl_t                ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	logic [32:0]         y_s1;
	logic [4:0]          ex_s2, ex_s3;
	logic [31:0]         frac_s2;
	logic [ROM_W-1:0]    t0_s3, t1_s3;
	logic [REM_BITS-1:0] rem_s3;
	logic [L2_W-1:0]     base_s4;
	logic [ROM_W+REM_BITS-1:0] prod_s4;
	logic [L2_W-1:0]     l2_s5;
	logic [L2_W+31:0]    lnp_s6;
	logic [LN_W-1:0]     ln_s7;

	logic [4:0]          ex_c;
	logic [48:0]         ysh_c;
	logic [ROM_AW-1:0]   idx_c;

	// control valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '{valid: 1'b0, status: ST_VALID};
			ctl_s2 <= '{valid: 1'b0, status: ST_VALID};
			ctl_s3 <= '{valid: 1'b0, status: ST_VALID};
			ctl_s4 <= '{valid: 1'b0, status: ST_VALID};
			ctl_s5 <= '{valid: 1'b0, status: ST_VALID};
			ctl_s6 <= '{valid: 1'b0, status: ST_VALID};
			ctl_s7 <= '{valid: 1'b0, status: ST_VALID};
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
		end
	end

	// leading one among bits 32..16 gives the exponent (minus 16)
	always_comb begin
		ex_c = '0;
		for (int b = 1; b <= 16; b++) begin
			if (y_s1[16+b]) begin
				ex_c = 5'(b);
			end
		end
		ysh_c = 49'(y_s1) << (5'd16 - ex_c);
		idx_c = ROM_AW'(frac_s2[31:REM_BITS]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: add 1.0
			y_s1    <= {1'b0, x} + 33'h1_0000;
			// s2: normalize
			ex_s2   <= ex_c;
			frac_s2 <= ysh_c[31:0];
			// s3: table reads at idx and idx+1
			ex_s3   <= ex_s2;
			t0_s3   <= LOG_ROM[idx_c];
			t1_s3   <= LOG_ROM[idx_c + ROM_AW'(1)];
			rem_s3  <= frac_s2[REM_BITS-1:0];
			// s4: interpolation product
			base_s4 <= {ex_s3, 24'b0} + L2_W'(t0_s3);
			prod_s4 <= (ROM_W+REM_BITS)'(t1_s3 - t0_s3) * (ROM_W+REM_BITS)'(rem_s3);
			// s5: log2 in Q.24
			l2_s5   <= base_s4 + L2_W'(prod_s4 >> REM_BITS);
			// s6: scale by ln(2)
			lnp_s6  <= (L2_W+32)'(l2_s5) * (L2_W+32)'(LN2_Q32);
			// s7: round
			ln_s7   <= LN_W'((lnp_s6 + (L2_W+32)'(64'h8000_0000)) >> 32);
		end
	end

	assign ctl_out = ctl_s7;
	assign ln      = ln_s7;

endmodule

>>> src/dn_to_brightness_temperature.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dn_to_brightness_temperature
// Thermal pixel to brightness temperature: radiance, K1 quotient, log, K2 quotient.
// Throughput: one word per cycle; every stage advances together, and holds
// while the output register is full and not taken.
// Reset: arst_n clears valid bits and loads configuration registers with their defaults.
// -----------------------------------------------------------------------------
module dn_to_brightness_temperature import dnbt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	dnbt_in_if.sink     pixel_in,
	dnbt_out_if.source  result_out,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0] gain_q, offset_q, k1_q, k2_q;
	logic [15:0] nodata_q;
	logic        nd_en_q;

	logic        en;
	ctl_t        fr_ctl, d1_ctl, lg_ctl, d2_ctl;
	logic [30:0] rad;
	logic [31:0] quot1, quot2;
	logic [LN_W-1:0] ln;
	logic        sat1, sat2;

	logic        out_valid_q;
	logic [31:0] temp_q;
	logic [1:0]  status_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= '0;
			offset_q <= '0;
			k1_q     <= 32'd1;
			k2_q     <= 32'd1;
			nodata_q <= '0;
			nd_en_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN:   gain_q   <= cfg_data;
				REG_OFFSET: offset_q <= cfg_data;
				REG_K1:     k1_q     <= cfg_data;
				REG_K2:     k2_q     <= cfg_data;
				REG_NODATA: nodata_q <= cfg_data[15:0];
				REG_ND_EN:  nd_en_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// whole pipeline moves unless the output word is stuck
	assign en             = !out_valid_q || result_out.ready;
	assign pixel_in.ready = en;

	dnbt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (pixel_in.valid),
		.pixel_dn      (pixel_in.pixel_dn),
		.gain          (gain_q),
		.offset        (offset_q),
		.nodata_pixel  (nodata_q),
		.nodata_enable (nd_en_q),
		.ctl_s2        (fr_ctl),
		.rad_s2        (rad)
	);

	// K1 * 2^16 / radiance, saturates when the quotient needs more than 32 bits
	assign sat1 = {16'b0, k1_q} >= {1'b0, rad, 16'b0};

	dnbt_div u_div_k1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (fr_ctl),
		.rem0    (DIV_W'(k1_q[31:16])),
		.num     ({k1_q[15:0], 16'b0}),
		.den     (DIV_W'(rad)),
		.sat     (sat1),
		.ctl_out (d1_ctl),
		.quot    (quot1)
	);

	dnbt_log u_log (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (d1_ctl),
		.x       (quot1),
		.ctl_out (lg_ctl),
		.ln      (ln)
	);

	// K2 * 2^24 / ln, a zero log also lands on saturation
	assign sat2 = {5'b0, k2_q} >= {ln, 8'b0};

	dnbt_div u_div_k2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (lg_ctl),
		.rem0    (DIV_W'(k2_q[31:8])),
		.num     ({k2_q[7:0], 24'b0}),
		.den     (DIV_W'(ln)),
		.sat     (sat2),
		.ctl_out (d2_ctl),
		.quot    (quot2)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= d2_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			temp_q   <= (d2_ctl.status == ST_VALID) ? quot2 : '0;
			status_q <= d2_ctl.status;
		end
	end

	assign result_out.valid              = out_valid_q;
	assign result_out.temperature_q16_16 = temp_q;
	assign result_out.pixel_status       = status_q;

endmodule

>>> test/dnbt_tb_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dnbt_tb_if
// Testbench build unit. The channel interfaces themselves
// live with the RTL; this file only holds the pipeline latency constant.
// -----------------------------------------------------------------------------
package dnbt_tb_if_pkg;
	// cycles from accepted pixel to result
	localparam int PIPE_LATENCY = 76;
endpackage

>>> test/dn_to_brightness_temperature_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dn_to_brightness_temperature_tb
// Streams thermal pixels through the brightness temperature pipeline under
// several calibration settings and handshake pressure patterns, predicting each
// result word in fixed point and checking it in order.
// -----------------------------------------------------------------------------
module dn_to_brightness_temperature_tb;
	import dnbt_pkg::*;
	import dnbt_tb_if_pkg::*;

	typedef struct {
		logic [31:0] temp;
		status_t     status;
	} bt_word_t;

	// calibration copy held by the predictor
	logic [31:0] cal_gain, cal_offset, cal_k1, cal_k2;
	logic [15:0] cal_nodata;
	logic        cal_nd_en;
	rom_t        log_rom;

	// log2 of Q2.30 mantissa, Q.24, independent of the package helper
	function automatic logic [24:0] mant_log2(logic [63:0] m_in);
		logic [63:0] m;
		logic [24:0] r;
		m = m_in;
		r = '0;
		if (m >= 64'h8000_0000) return 25'h100_0000;
		for (int k = 0; k < 24; k++) begin
			r = r << 1;
			m = (m * m) >> 30;
			if (m >= 64'h8000_0000) begin
				m = m >> 1;
				r[0] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] ln_of(logic [63:0] y);
		int e;
		logic [63:0] fr, idx, rm, t0, t1, l2;
		logic [127:0] prod;
		e = 32;
		while (e > 16 && y[e] == 1'b0) e--;
		fr = (y << (32 - e)) - (64'd1 << 32);
		idx = fr >> (32 - LOG_TABLE_BITS);
		rm = fr & ((64'd1 << (32 - LOG_TABLE_BITS)) - 1);
		t0 = log_rom[idx];
		t1 = log_rom[idx + 1];
		l2 = (64'(e - 16) << 24) + t0 + (((t1 - t0) * rm) >> (32 - LOG_TABLE_BITS));
		prod = 128'(l2) * 128'(LN2_Q32) + (128'd1 << 31);
		return 64'(prod >> 32);
	endfunction

	function automatic bt_word_t predict_temp(logic [15:0] dn);
		bt_word_t w;
		longint p, x, rad;
		logic [63:0] q, l, t;
		w.temp = '0;
		if (cal_nd_en && dn == cal_nodata) begin
			w.status = ST_NODATA;
			return w;
		end
		p = longint'($signed(cal_gain)) * longint'({48'd0, dn});
		x = p + 128;
		rad = (x >>> 8) + longint'($signed(cal_offset));
		if (rad > 64'sd2147483647) rad = 64'sd2147483647;
		if (rad <= 0) begin
			w.status = ST_BADRAD;
			return w;
		end
		q = ({32'd0, cal_k1} << 16) / 64'(rad);
		if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
		l = ln_of(q + 64'h1_0000);
		if (l == 0) t = 64'hFFFF_FFFF;
		else begin
			t = ({32'd0, cal_k2} << 24) / l;
			if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
		end
		w.temp = t[31:0];
		w.status = ST_VALID;
		return w;
	endfunction

	// in-order store of expected result words
	class temp_scoreboard;
		bt_word_t pending[$];
		int errors = 0;
		int checked = 0;
		function void note_pixel(bt_word_t w);
			pending.push_back(w);
		endfunction
		function void check_word(logic [31:0] temp, logic [1:0] st);
			bt_word_t e;
			checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result word temp=%h st=%0d", temp, st);
				return;
			end
			e = pending.pop_front();
			if (temp !== e.temp || st !== e.status) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp temp=%h st=%0d, got temp=%h st=%0d",
						e.temp, e.status, temp, st);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	dnbt_in_if pixel_in();
	dnbt_out_if result_out();

	dn_to_brightness_temperature u_dut (
		.clk(clk), .arst_n(arst_n),
		.pixel_in(pixel_in.sink), .result_out(result_out.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	temp_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 0;
	int idle_cycles = 0;
	int pixels_sent = 0;
	int settings_run = 0;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		pixel_in.valid = 0;
		pixel_in.pixel_dn = '0;
		result_out.ready = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
	end

	// result side: random stall or long hold-off, check on each accepted word
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_out.valid && result_out.ready)
				sb.check_word(result_out.temperature_q16_16, result_out.pixel_status);
			result_out.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((pixel_in.valid && pixel_in.ready) || (result_out.valid && result_out.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("timeout waiting on handshake");
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// one register write, with cfg_we dropped again before the next one
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_GAIN:   cal_gain = val;
			REG_OFFSET: cal_offset = val;
			REG_K1:     cal_k1 = val;
			REG_K2:     cal_k2 = val;
			REG_NODATA: cal_nodata = val[15:0];
			REG_ND_EN:  cal_nd_en = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_calib(logic [31:0] g, logic [31:0] o, logic [31:0] k1,
			logic [31:0] k2, logic [15:0] nd, logic en);
		write_reg(REG_GAIN, g);
		write_reg(REG_OFFSET, o);
		write_reg(REG_K1, k1);
		write_reg(REG_K2, k2);
		write_reg(REG_NODATA, {16'd0, nd});
		write_reg(REG_ND_EN, {31'd0, en});
		settings_run++;
	endtask

	// offer one pixel word, hold until accepted; valid stays up for the next
	task automatic send_pixel(logic [15:0] dn);
		while ($urandom_range(99) < send_idle_pct) begin
			pixel_in.valid <= 0;
			@(posedge clk);
		end
		pixel_in.valid <= 1;
		pixel_in.pixel_dn <= dn;
		@(posedge clk);
		while (!pixel_in.ready) @(posedge clk);
		sb.note_pixel(predict_temp(dn));
		pixels_sent++;
	endtask

	task automatic drain();
		pixel_in.valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_dn();
		case ($urandom_range(5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'(cal_nodata);
			default: return 16'($urandom());
		endcase
	endfunction

	// batch of random pixels; back-to-back unless the sender idles or the pipeline holds
	task automatic random_batch(int n);
		for (int i = 0; i < n; i++) send_pixel(rand_dn());
	endtask

	initial begin
		cal_gain = 0; cal_offset = 0; cal_k1 = 1; cal_k2 = 1;
		cal_nodata = 0; cal_nd_en = 0;
		log_rom = '{default: '0};
		for (int i = 0; i < ROM_DEPTH; i++)
			log_rom[i] = mant_log2((64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS)));
		@(posedge arst_n);
		@(posedge clk);

		// defaults: zero gain, zero offset -> radiance not positive
		send_pixel(16'h1234);
		drain();

		// typical thermal band calibration with no-data matching
		set_calib(32'h0000_0056, 32'h0000_199A, 32'h0310_0000, 32'h0520_0000, 16'd0, 1);
		send_pixel(16'h0000);
		send_pixel(16'h0001);
		send_pixel(16'hFFFF);
		send_pixel(16'h8000);
		send_pixel(16'h7FFF);
		drain();
		// zero K1, all-ones K2, out of range index, large gain with saturation
		set_calib(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 1);
		write_reg(3'd6, 32'hDEAD_BEEF);
		write_reg(3'd7, 32'h1234_5678);
		send_pixel(16'hFFFF);
		send_pixel(16'h0001);
		send_pixel(16'h0000);
		drain();
		set_calib(32'h0100_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'd0, 16'h5555, 0);
		send_pixel(16'h5555);
		send_pixel(16'h0000);
		send_pixel(16'h0001);
		send_pixel(16'hFFFF);
		drain();
		// negative gain and extreme negative offset
		set_calib(32'h8000_0000, 32'h8000_0000, 32'h0001_0000, 32'h0001_0000, 16'hAAAA, 1);
		send_pixel(16'hAAAA);
		send_pixel(16'h0000);
		send_pixel(16'h0001);
		drain();
		set_calib(32'hFF00_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0001, 16'h0000, 0);
		send_pixel(16'hFFFF);
		send_pixel(16'h0000);
		drain();

		// random phases with varied calibration and handshake pressure
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			if (ph < 2)
				set_calib(32'h0000_0000 + $urandom_range(32'h0000_4000),
					$urandom_range(32'h0040_0000), 32'h0300_0000 + $urandom_range(32'h00FF_FFFF),
					32'h0500_0000 + $urandom_range(32'h00FF_FFFF), 16'($urandom()),
					1'($urandom()));
			else
				set_calib($urandom(), $urandom(), $urandom(), $urandom(),
					16'($urandom()), 1'($urandom()));
			if (ph == 2) begin
				// receiver holds off long enough for the pipeline to back up
				fork
					begin
						hold_off = 1;
						repeat (300) @(posedge clk);
						hold_off = 0;
					end
					random_batch(130);
				join
			end else begin
				random_batch(130);
			end
			drain();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();
		$display("run covered %0d pixels over %0d calibration settings, %0d results checked",
			pixels_sent, settings_run, sb.checked);
		$display("phases: back-to-back, sender gaps, receiver stalls, both, and a long hold-off");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> files.f
src/dnbt_pkg.sv
src/dnbt_if.sv
src/dnbt_front.sv
src/dnbt_div.sv
src/dnbt_log.sv
src/dn_to_brightness_temperature.sv
test/dnbt_tb_if.sv
test/dn_to_brightness_temperature_tb.sv
